FILE: rtl/core/vwhp_pkg.sv
// Shared types and constants for the sound file header parser.
`timescale 1ns / 1ps
package vwhp_pkg;

   localparam int unsigned HEADER_STORE_BYTES_DEF = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_LC_R = 8'h72;
   localparam logic [7:0] CHAR_R = 8'h52;
   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] CHAR_W = 8'h57;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_V = 8'h56;
   localparam logic [7:0] CHAR_E = 8'h45;

   localparam logic [31:0] VOC_MIN_SIZE = 32'h1A;
   localparam logic [31:0] WAV_MIN_SIZE = 32'd44;
   localparam logic [31:0] VOC_OFS_LO = 32'h14;
   localparam logic [31:0] VOC_OFS_HI = 32'h15;
   localparam logic [4:0] VOC_REPLAY_LAST = 5'h15;
   localparam logic [15:0] VOC_REPLAY_END = 16'h16;

   // VOC time constant base clock: rate = VOC_CLOCK / (256 - tc)
   localparam int unsigned VOC_CLOCK_W = 20;
   localparam logic [VOC_CLOCK_W-1:0] VOC_CLOCK = 20'd1000000;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_VOC_HDR,
      PH_VOC_BLK,
      PH_VOC_BODY,
      PH_WAV_HDR,
      PH_WAV_CHK,
      PH_WAV_FMT,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      FR_RUN,
      FR_RD,
      FR_EX
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic        status;
      logic        is_voc;
      logic        need_div;
      logic [31:0] rate;
      logic [7:0]  bits;
      logic [7:0]  ch;
      logic [31:0] off;
      logic [31:0] len;
   } result_type;

endpackage

FILE: rtl/core/vwhp_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vwhp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/vwhp_front.sv
// Front end: byte intake, header checks, chunk/block walk and VOC offset replay.
`timescale 1ns / 1ps
module vwhp_front #(
   parameter int unsigned HEADER_STORE_BYTES = vwhp_pkg::HEADER_STORE_BYTES_DEF,
   localparam int unsigned AW = $clog2(HEADER_STORE_BYTES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_file_byte,
   input  logic [31:0]          req_file_size,
   input  logic                 req_last_byte,
   input  logic                 q_full,
   output logic                 push,
   output vwhp_pkg::result_type push_data
);

   vwhp_pkg::front_state_type ctl_ff, ctl_in;
   vwhp_pkg::phase_type phase_ff, phase_in;

   logic [31:0] pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] skip_ff, skip_in;
   logic        fmt_ff, fmt_in;
   logic [31:0] rate_ff, rate_in;
   logic [7:0]  bits_ff, bits_in;
   logic [7:0]  ch_ff, ch_in;
   logic [32:0] walk_ff, walk_in;
   logic [32:0] item_ff, item_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        voc_ff, voc_in;
   logic        dec_ff, dec_in;
   logic [4:0]  rcur_ff, rcur_in;
   logic [31:0] size_ff;
   logic        lastp_ff;

   logic          live;
   logic          rep_ex;
   logic          go_replay;
   logic          rep_done;
   logic [7:0]    ram_rdata;
   logic [AW-1:0] ram_addr;
   logic          ram_we;

   vwhp_ram #(
      .WIDTH(8),
      .DEPTH(HEADER_STORE_BYTES)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_file_byte),
      .rdata(ram_rdata)
   );

   // control FSM: next state
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         vwhp_pkg::FR_RUN: if (live && go_replay) ctl_in = vwhp_pkg::FR_RD;
         vwhp_pkg::FR_RD:  ctl_in = vwhp_pkg::FR_EX;
         vwhp_pkg::FR_EX:  if (rep_done) ctl_in = vwhp_pkg::FR_RUN; else ctl_in = vwhp_pkg::FR_RD;
         default:          ctl_in = vwhp_pkg::FR_RUN;
      endcase
   end

   // control FSM: outputs
   always_comb begin
      req_stall = q_full || (ctl_ff != vwhp_pkg::FR_RUN);
      rep_ex = (ctl_ff == vwhp_pkg::FR_EX);
      ram_we = 1'b0;
      ram_addr = pos_ff[AW-1:0];
      unique case (ctl_ff)
         vwhp_pkg::FR_RUN: ram_we = live && (pos_ff < 32'(HEADER_STORE_BYTES));
         vwhp_pkg::FR_RD,
         vwhp_pkg::FR_EX:  ram_addr = AW'(rcur_ff);
         default:          ram_we = 1'b0;
      endcase
   end

   assign live = req_valid && !req_stall;

   always_comb begin
      logic [33:0] sz34;
      logic [33:0] q34;
      logic [33:0] jp34;
      logic [31:0] acc_new;
      logic [31:0] px;
      logic [15:0] off16;
      logic [7:0]  bx;
      logic        jv;
      logic        jw;
      logic        want_rep;
      logic        fail_now;
      logic        succ_now;
      logic        finish;
      logic        last_eff;
      logic        lastfail;
      logic        exec;
      vwhp_pkg::result_type res;

      phase_in = phase_ff;
      pos_in = pos_ff;
      acc_in = acc_ff;
      id_in = id_ff;
      skip_in = skip_ff;
      fmt_in = fmt_ff;
      rate_in = rate_ff;
      bits_in = bits_ff;
      ch_in = ch_ff;
      walk_in = walk_ff;
      item_in = item_ff;
      cnt_in = cnt_ff;
      voc_in = voc_ff;
      dec_in = dec_ff;
      rcur_in = rcur_ff;

      exec = live || rep_ex;
      bx = rep_ex ? ram_rdata : req_file_byte;
      px = rep_ex ? {27'd0, rcur_ff} : pos_ff;
      sz34 = {2'b00, (rep_ex ? size_ff : req_file_size)};
      q34 = '0;
      jp34 = '0;
      acc_new = acc_ff;
      off16 = '0;
      jv = 1'b0;
      jw = 1'b0;
      want_rep = 1'b0;
      fail_now = 1'b0;
      succ_now = 1'b0;
      res = '0;

      if (exec && !dec_ff) begin
         unique case (phase_ff) inside
            vwhp_pkg::PH_FIRST: begin
               voc_in = (bx == vwhp_pkg::CHAR_C);
               if (sz34 == '0) begin
                  fail_now = 1'b1;
               end else if (voc_in) begin
                  if (sz34 < 34'(vwhp_pkg::VOC_MIN_SIZE)) fail_now = 1'b1;
                  else phase_in = vwhp_pkg::PH_VOC_HDR;
               end else begin
                  if (sz34 < 34'(vwhp_pkg::WAV_MIN_SIZE) || bx != vwhp_pkg::CHAR_R)
                     fail_now = 1'b1;
                  else phase_in = vwhp_pkg::PH_WAV_HDR;
               end
            end
            vwhp_pkg::PH_VOC_HDR: begin
               if (px == 32'd1 && bx != vwhp_pkg::CHAR_LC_R) begin
                  fail_now = 1'b1;
               end else begin
                  if (px == vwhp_pkg::VOC_OFS_LO) acc_in = {24'd0, bx};
                  if (px == vwhp_pkg::VOC_OFS_HI) begin
                     off16 = {bx, acc_ff[7:0]};
                     if (34'(off16) >= sz34) begin
                        fail_now = 1'b1;
                     end else begin
                        jv = 1'b1;
                        jp34 = 34'(off16);
                        want_rep = (off16 < vwhp_pkg::VOC_REPLAY_END);
                     end
                  end
               end
            end
            vwhp_pkg::PH_WAV_HDR: begin
               if ((px == 32'd1 && bx != vwhp_pkg::CHAR_I) ||
                   (px == 32'd2 && bx != vwhp_pkg::CHAR_F) ||
                   (px == 32'd3 && bx != vwhp_pkg::CHAR_F) ||
                   (px == 32'd8 && bx != vwhp_pkg::CHAR_W) ||
                   (px == 32'd9 && bx != vwhp_pkg::CHAR_A) ||
                   (px == 32'd10 && bx != vwhp_pkg::CHAR_V) ||
                   (px == 32'd11 && bx != vwhp_pkg::CHAR_E)) begin
                  fail_now = 1'b1;
               end else if (px == 32'd11) begin
                  jw = 1'b1;
                  jp34 = 34'd12;
               end
            end
            vwhp_pkg::PH_VOC_BLK, vwhp_pkg::PH_VOC_BODY,
            vwhp_pkg::PH_WAV_CHK, vwhp_pkg::PH_WAV_FMT: begin
               if ({1'b0, px} == walk_ff) begin
                  walk_in = walk_ff + 33'd1;
                  cnt_in = cnt_ff + 5'd1;
                  case (phase_ff)
                     vwhp_pkg::PH_VOC_BLK: begin
                        if (cnt_ff == 5'd0) begin
                           id_in = {24'd0, bx};
                           if (bx == 8'd0) fail_now = 1'b1;
                        end else begin
                           acc_new = acc_ff | (32'(bx) << {cnt_ff[1:0] - 2'd1, 3'b000});
                           acc_in = acc_new;
                           if (cnt_ff == 5'd3) begin
                              q34 = 34'(item_ff) + 34'd4;
                              skip_in = acc_new;
                              if (sz34 - q34 < 34'(acc_new)) begin
                                 fail_now = 1'b1;
                              end else if ((id_ff == 32'd1 && acc_new >= 32'd2) ||
                                           (id_ff == 32'd9 && acc_new >= 32'd12)) begin
                                 phase_in = vwhp_pkg::PH_VOC_BODY;
                                 item_in = 33'(q34);
                                 walk_in = 33'(q34);
                                 cnt_in = '0;
                                 acc_in = '0;
                              end else begin
                                 jv = 1'b1;
                                 jp34 = q34 + 34'(acc_new);
                              end
                           end
                        end
                     end
                     vwhp_pkg::PH_VOC_BODY: begin
                        if (id_ff == 32'd1) begin
                           succ_now = 1'b1;
                           res.need_div = 1'b1;
                           res.rate = 32'(9'd256 - {1'b0, bx});
                           res.bits = 8'd8;
                           res.ch = 8'd1;
                           res.off = 32'(item_ff + 33'd2);
                           res.len = skip_ff - 32'd2;
                        end else if (cnt_ff < 5'd4) begin
                           acc_in = acc_ff | (32'(bx) << {cnt_ff[1:0], 3'b000});
                        end else if (cnt_ff == 5'd4) begin
                           rate_in = '0;
                           bits_in = bx;
                           ch_in = '0;
                        end else begin
                           succ_now = 1'b1;
                           res.rate = acc_ff;
                           res.bits = bits_ff;
                           res.ch = bx;
                           res.off = 32'(item_ff + 33'd12);
                           res.len = skip_ff - 32'd12;
                        end
                     end
                     vwhp_pkg::PH_WAV_CHK: begin
                        if (cnt_ff < 5'd4) begin
                           id_in = id_ff | (32'(bx) << {cnt_ff[1:0], 3'b000});
                        end else begin
                           acc_new = acc_ff | (32'(bx) << {cnt_ff[1:0], 3'b000});
                           acc_in = acc_new;
                           if (cnt_ff == 5'd7) begin
                              q34 = 34'(item_ff) + 34'd8;
                              skip_in = acc_new;
                              if (sz34 - q34 < 34'(acc_new)) begin
                                 fail_now = 1'b1;
                              end else if (id_ff == vwhp_pkg::ID_FMT && acc_new >= 32'd16) begin
                                 phase_in = vwhp_pkg::PH_WAV_FMT;
                                 item_in = 33'(q34);
                                 walk_in = 33'(q34);
                                 cnt_in = '0;
                                 acc_in = '0;
                              end else if (id_ff == vwhp_pkg::ID_DATA) begin
                                 if (!fmt_ff) begin
                                    fail_now = 1'b1;
                                 end else begin
                                    succ_now = 1'b1;
                                    res.rate = rate_ff;
                                    res.bits = bits_ff;
                                    res.ch = ch_ff;
                                    res.off = q34[31:0];
                                    res.len = acc_new;
                                 end
                              end else begin
                                 jw = 1'b1;
                                 jp34 = q34 + 34'(acc_new) + 34'(acc_new[0]);
                              end
                           end
                        end
                     end
                     vwhp_pkg::PH_WAV_FMT: begin
                        if (cnt_ff == 5'd0) begin
                           acc_in = {24'd0, bx};
                        end else if (cnt_ff == 5'd1) begin
                           if ({bx, acc_ff[7:0]} != 16'd1) fail_now = 1'b1;
                        end else if (cnt_ff == 5'd2) begin
                           ch_in = bx;
                        end else if (cnt_ff >= 5'd4 && cnt_ff <= 5'd7) begin
                           rate_in[{cnt_ff[1:0], 3'b000} +: 8] = bx;
                        end else if (cnt_ff == 5'd14) begin
                           bits_in = bx;
                        end else if (cnt_ff == 5'd15) begin
                           fmt_in = 1'b1;
                           jw = 1'b1;
                           jp34 = 34'(item_ff) + 34'(skip_ff) + 34'(skip_ff[0]);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase

         // enter the next VOC block or WAV chunk
         if (jv && !fail_now) begin
            if (jp34 + 34'd4 > sz34) begin
               fail_now = 1'b1;
            end else begin
               phase_in = vwhp_pkg::PH_VOC_BLK;
               walk_in = 33'(jp34);
               item_in = 33'(jp34);
               cnt_in = '0;
               acc_in = '0;
            end
         end
         if (jw && !fail_now) begin
            if (jp34 + 34'd8 > sz34) begin
               fail_now = 1'b1;
            end else begin
               phase_in = vwhp_pkg::PH_WAV_CHK;
               walk_in = 33'(jp34);
               item_in = 33'(jp34);
               cnt_in = '0;
               acc_in = '0;
               id_in = '0;
            end
         end
      end

      go_replay = live && want_rep && !fail_now;
      rep_done = (rcur_ff == vwhp_pkg::VOC_REPLAY_LAST) || fail_now || succ_now;
      if (go_replay) rcur_in = off16[4:0];
      else if (rep_ex) rcur_in = rcur_ff + 5'd1;

      finish = (live && !go_replay) || (rep_ex && rep_done);
      last_eff = rep_ex ? lastp_ff : req_last_byte;
      lastfail = finish && last_eff && !dec_ff && !fail_now && !succ_now;

      if (fail_now || lastfail) res = '0;
      res.status = fail_now || lastfail;
      res.is_voc = voc_in;
      push = exec && !dec_ff && (fail_now || succ_now || lastfail);
      push_data = res;

      if (fail_now || succ_now || lastfail) begin
         dec_in = 1'b1;
         phase_in = vwhp_pkg::PH_DONE;
      end

      if (live) pos_in = (pos_ff == '1) ? pos_ff : pos_ff + 32'd1;

      // restart for the next file
      if (finish && last_eff) begin
         pos_in = '0;
         phase_in = vwhp_pkg::PH_FIRST;
         acc_in = '0;
         id_in = '0;
         skip_in = '0;
         fmt_in = 1'b0;
         rate_in = '0;
         bits_in = '0;
         ch_in = '0;
         walk_in = '0;
         item_in = '0;
         cnt_in = '0;
         voc_in = 1'b0;
         dec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= vwhp_pkg::FR_RUN;
         phase_ff <= vwhp_pkg::PH_FIRST;
         pos_ff <= '0;
         acc_ff <= '0;
         id_ff <= '0;
         skip_ff <= '0;
         fmt_ff <= 1'b0;
         rate_ff <= '0;
         bits_ff <= '0;
         ch_ff <= '0;
         walk_ff <= '0;
         item_ff <= '0;
         cnt_ff <= '0;
         voc_ff <= 1'b0;
         dec_ff <= 1'b0;
         rcur_ff <= '0;
         lastp_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         id_ff <= id_in;
         skip_ff <= skip_in;
         fmt_ff <= fmt_in;
         rate_ff <= rate_in;
         bits_ff <= bits_in;
         ch_ff <= ch_in;
         walk_ff <= walk_in;
         item_ff <= item_in;
         cnt_ff <= cnt_in;
         voc_ff <= voc_in;
         dec_ff <= dec_in;
         rcur_ff <= rcur_in;
         if (live) lastp_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (live) size_ff <= req_file_size;
   end

`ifndef SYNTHESIS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("result pushed into a full queue");
   a_replay_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == vwhp_pkg::FR_EX) |-> (rcur_ff <= vwhp_pkg::VOC_REPLAY_LAST))
      else $error("replay cursor past header offset field");
   a_decided_done: assert property (@(posedge clock) disable iff (reset)
      dec_ff |-> (phase_ff == vwhp_pkg::PH_DONE))
      else $error("decided file not in done phase");
`endif

endmodule

FILE: rtl/core/vwhp_queue.sv
// Short result queue between the parser front end and the output stage.
`timescale 1ns / 1ps
module vwhp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vwhp_pkg::result_type push_data,
   output logic                 full,
   input  logic                 pop,
   output vwhp_pkg::result_type pop_data,
   output logic                 empty
);

   localparam int unsigned PTR_W = vwhp_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = $clog2(vwhp_pkg::QUEUE_DEPTH + 1);

   vwhp_pkg::result_type mem_ff [vwhp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == CNT_W'(vwhp_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(vwhp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(vwhp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push && full && !pop) |=> (cnt_ff == $past(cnt_ff)))
      else $error("queue overflow");
`endif

endmodule

FILE: rtl/core/vwhp_back.sv
// Back end: VOC time constant division and result output register.
`timescale 1ns / 1ps
module vwhp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  vwhp_pkg::result_type q_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vwhp_pkg::result_type rsp_data
);

   localparam int unsigned QW = vwhp_pkg::VOC_CLOCK_W;
   localparam int unsigned STEP_W = $clog2(QW);

   vwhp_pkg::back_state_type st_ff, st_in;
   vwhp_pkg::result_type out_ff;
   logic [QW-1:0]     dvd_ff, dvd_in;
   logic [8:0]        rem_ff, rem_in;
   logic [8:0]        dvsr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              div_last;

   // one restoring division step per cycle
   always_comb begin
      logic [9:0] rs;
      rs = {rem_ff, dvd_ff[QW-1]};
      if (rs >= {1'b0, dvsr_ff}) begin
         rem_in = 9'(rs - {1'b0, dvsr_ff});
         dvd_in = {dvd_ff[QW-2:0], 1'b1};
      end else begin
         rem_in = rs[8:0];
         dvd_in = {dvd_ff[QW-2:0], 1'b0};
      end
   end

   assign div_last = (step_ff == STEP_W'(QW - 1));

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         vwhp_pkg::BK_IDLE: begin
            if (!q_empty) st_in = q_data.need_div ? vwhp_pkg::BK_DIV : vwhp_pkg::BK_OUT;
         end
         vwhp_pkg::BK_DIV: if (div_last) st_in = vwhp_pkg::BK_OUT;
         vwhp_pkg::BK_OUT: if (!rsp_stall) st_in = vwhp_pkg::BK_IDLE;
         default:          st_in = vwhp_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      rsp_valid = 1'b0;
      unique case (st_ff)
         vwhp_pkg::BK_IDLE: pop = !q_empty;
         vwhp_pkg::BK_DIV:  pop = 1'b0;
         vwhp_pkg::BK_OUT:  rsp_valid = 1'b1;
         default:           pop = 1'b0;
      endcase
   end

   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vwhp_pkg::BK_IDLE;
         step_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (pop) step_ff <= '0;
         else if (st_ff == vwhp_pkg::BK_DIV) step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= q_data;
         dvsr_ff <= q_data.rate[8:0];
         dvd_ff <= vwhp_pkg::VOC_CLOCK;
         rem_ff <= '0;
      end else if (st_ff == vwhp_pkg::BK_DIV) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         if (div_last) out_ff.rate <= 32'(dvd_in);
      end
   end

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == vwhp_pkg::BK_DIV) |-> (dvsr_ff != '0))
      else $error("division by zero time constant");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && out_ff == $past(out_ff)))
      else $error("stalled result changed");
`endif

endmodule

FILE: rtl/core/voc_wav_header_parser_core.sv
// Sound file header parser (RIFF/WAVE and VOC) top level.
// The file streams in on the req_ channel, one byte per transaction, with its
// total size on every byte and last_byte on the final one. One result per
// file leaves on the rsp_ channel: status, format, rate, bits, channels and
// the offset and length of the PCM data. Bytes after the decision are dropped
// until last_byte, then the parser starts over with the next file.
// Throughput: one byte per cycle while req_stall is low. A VOC file whose block
// offset points into the header stalls req_ after byte 0x15 while the header
// bytes from that offset up to 0x15 are read back from the byte store.
// A result enters the 2-entry queue at the byte that decides it and reaches
// rsp_ via the output register, after a division for a VOC time constant
// block (one quotient bit per cycle). req_stall rises while the queue is full.
// A stalled rsp_ transaction holds its payload; the front keeps parsing until
// the queue fills. Reset is synchronous and returns the parser to the first
// byte of a file with the queue and output empty. The header byte store holds
// no reset value and needs no clearing.
`timescale 1ns / 1ps
module voc_wav_header_parser_core #(
   parameter int unsigned HEADER_STORE_BYTES = vwhp_pkg::HEADER_STORE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic [31:0] req_file_size,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_is_voc,
   output logic [31:0] rsp_sample_rate,
   output logic [7:0]  rsp_bits_per_sample,
   output logic [7:0]  rsp_channel_count,
   output logic [31:0] rsp_pcm_offset,
   output logic [31:0] rsp_pcm_length
);

   logic                 q_full;
   logic                 q_empty;
   logic                 push;
   logic                 pop;
   vwhp_pkg::result_type push_data;
   vwhp_pkg::result_type pop_data;
   vwhp_pkg::result_type rsp_data;

   vwhp_front #(
      .HEADER_STORE_BYTES(HEADER_STORE_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_file_byte(req_file_byte),
      .req_file_size(req_file_size),
      .req_last_byte(req_last_byte),
      .q_full       (q_full),
      .push         (push),
      .push_data    (push_data)
   );

   vwhp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (q_empty)
   );

   vwhp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (pop_data),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign rsp_status = rsp_data.status;
   assign rsp_is_voc = rsp_data.is_voc;
   assign rsp_sample_rate = rsp_data.rate;
   assign rsp_bits_per_sample = rsp_data.bits;
   assign rsp_channel_count = rsp_data.ch;
   assign rsp_pcm_offset = rsp_data.off;
   assign rsp_pcm_length = rsp_data.len;

endmodule
